[sv/polar_point_to_occupancy_grid_core_assert.svh]
// Assertion macros for the polar point to occupancy grid core.
// Taken in by `include; bodies are empty when SYNTHESIS is defined.
`ifndef POLAR_POINT_TO_OCCUPANCY_GRID_CORE_ASSERT_SVH
`define POLAR_POINT_TO_OCCUPANCY_GRID_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define PP2OG_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pp2og same-cycle check failed");
`define PP2OG_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pp2og next-cycle check failed");
`else
`define PP2OG_ASSERT_IMP(label, clk, rst, ante, cons)
`define PP2OG_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

[sv/pp2og_pkg.sv]
// Shared types, command codes and the quarter-wave sine table.
// No dependencies; used by every other file of the core but the assertion header.
package pp2og_pkg;

   localparam int CMD_W   = 2;
   localparam int DIST_W  = 16;
   localparam int ANGLE_W = 11;
   localparam int COORD_W = 7;

   localparam logic [CMD_W-1:0] CMD_PLOT  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   localparam logic [ANGLE_W-1:0] ANGLE_QUARTER = 11'd900;
   localparam logic [ANGLE_W-1:0] ANGLE_HALF    = 11'd1800;
   localparam logic [ANGLE_W-1:0] ANGLE_LAST    = 11'd1799;

   localparam int ROM_LEN = 901;
   localparam int ROM_AW  = 10;
   localparam int TRIG_W  = 17;

   localparam logic [63:0] PI_Q30 = 64'd3373259426;
   // (2n)(2n+1) for the Taylor terms
   localparam logic [63:0] TAYLOR_DIV [1:9] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
                                               64'd156, 64'd210, 64'd272, 64'd342};

   typedef logic [TRIG_W-1:0] trig_rom_type [ROM_LEN];

   typedef struct packed {
      logic wr_en;
      logic clear;
   } ram_ctl_type;

   typedef struct packed {
      logic start;
      logic left;   // angle at or past 90 degrees
      logic cneg;   // cosine negative
   } calc_ctl_type;

   // sin(k*pi/1800) in Q1.16 via a ten-term series in Q2.30
   function automatic trig_rom_type build_trig_rom();
      trig_rom_type rom;
      logic [63:0] theta;
      logic [63:0] t2;
      logic [63:0] term;
      logic signed [63:0] sum;
      logic [63:0] q;
      for (int k = 0; k < ROM_LEN; k++) begin
         theta = (64'(k) * PI_Q30 + 64'd900) / 64'd1800;
         t2 = (theta * theta) >> 30;
         term = theta;
         sum = $signed(theta);
         for (int n = 1; n < 10; n++) begin
            term = ((term * t2) >> 30) / TAYLOR_DIV[n];
            if ((n & 1) != 0) begin
               sum = sum - $signed(term);
            end else begin
               sum = sum + $signed(term);
            end
         end
         if (sum < 0) begin
            sum = '0;
         end
         q = (64'(sum) + 64'd8192) >> 14;
         if (q > 64'd65536) begin
            q = 64'd65536;
         end
         rom[k] = TRIG_W'(q);
      end
      return rom;
   endfunction

   localparam trig_rom_type TRIG_ROM = build_trig_rom();

endpackage

[sv/pp2og_if.sv]
// Request and response channel interfaces with valid/ready handshake.
// Field widths come from pp2og_pkg.
interface pp2og_req_if;
   logic                             valid;
   logic                             ready;
   logic [pp2og_pkg::CMD_W-1:0]      command;
   logic [pp2og_pkg::DIST_W-1:0]     distance_cm;
   logic [pp2og_pkg::ANGLE_W-1:0]    angle_tenths;
   logic [pp2og_pkg::COORD_W-1:0]    read_x;
   logic [pp2og_pkg::COORD_W-1:0]    read_y;

   modport source (output valid, output command, output distance_cm, output angle_tenths,
                   output read_x, output read_y, input ready);
   modport sink   (input valid, input command, input distance_cm, input angle_tenths,
                   input read_x, input read_y, output ready);
endinterface

interface pp2og_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [pp2og_pkg::COORD_W-1:0]    cell_x;
   logic [pp2og_pkg::COORD_W-1:0]    cell_y;
   logic                             cell_value;
   logic                             done_res;

   modport source (output valid, output cell_x, output cell_y, output cell_value,
                   output done_res, input ready);
   modport sink   (input valid, input cell_x, input cell_y, input cell_value,
                   input done_res, output ready);
endinterface

[sv/pp2og_trig_rom.sv]
// Quarter-wave sine ROM with two registered read ports.
// Table contents come from pp2og_pkg::TRIG_ROM.
module pp2og_trig_rom (
   input  logic                            clock,
   input  logic [pp2og_pkg::ROM_AW-1:0]    sin_addr,
   input  logic [pp2og_pkg::ROM_AW-1:0]    cos_addr,
   output logic [pp2og_pkg::TRIG_W-1:0]    sin_q,
   output logic [pp2og_pkg::TRIG_W-1:0]    cos_q
);

   logic [pp2og_pkg::TRIG_W-1:0] sin_ff;
   logic [pp2og_pkg::TRIG_W-1:0] cos_ff;

   always_ff @(posedge clock) begin
      sin_ff <= pp2og_pkg::TRIG_ROM[sin_addr];
      cos_ff <= pp2og_pkg::TRIG_ROM[cos_addr];
   end

   assign sin_q = sin_ff;
   assign cos_q = cos_ff;

endmodule

[sv/pp2og_map_ram.sv]
// Occupancy map storage: one row of cells per word, registered read.
// Per-row valid flops make reset and clear instant. Uses pp2og_pkg.
module pp2og_map_ram #(
   parameter int MAP_SIZE = 120
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pp2og_pkg::ram_ctl_type        ctl,
   input  logic [$clog2(MAP_SIZE)-1:0]   rd_addr,
   input  logic [$clog2(MAP_SIZE)-1:0]   wr_addr,
   input  logic [MAP_SIZE-1:0]           wr_row,
   output logic [MAP_SIZE-1:0]           rd_row
);

   logic [MAP_SIZE-1:0] row_mem_ff [MAP_SIZE];
   logic [MAP_SIZE-1:0] rd_data_ff;
   logic                rd_valid_ff;
   logic [MAP_SIZE-1:0] row_valid_ff;
   logic [MAP_SIZE-1:0] row_valid_in;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         row_mem_ff[wr_addr] <= wr_row;
      end
      rd_data_ff <= row_mem_ff[rd_addr];
   end

   always_comb begin
      row_valid_in = row_valid_ff;
      if (ctl.clear) begin
         row_valid_in = '0;
      end else if (ctl.wr_en) begin
         row_valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         row_valid_ff <= row_valid_in;
         rd_valid_ff  <= row_valid_ff[rd_addr];
      end
   end

   // a row never written since the last clear reads as empty
   assign rd_row = rd_valid_ff ? rd_data_ff : '0;

endmodule

[sv/pp2og_cell_calc.sv]
// Three-stage polar to cell datapath: range times trig, divide by
// cell size, layout offset and saturation. Uses pp2og_pkg.
module pp2og_cell_calc #(
   parameter int MAP_SIZE    = 120,
   parameter int CM_PER_CELL = 20,
   parameter int MAX_RANGE   = 1200
) (
   input  logic                           clock,
   input  logic                           reset,
   input  pp2og_pkg::calc_ctl_type        ctl,
   input  logic [$clog2(MAX_RANGE)-1:0]   range_cm,
   input  logic [pp2og_pkg::TRIG_W-1:0]   sin_val,
   input  logic [pp2og_pkg::TRIG_W-1:0]   cos_val,
   output logic                           out_valid,
   output logic [$clog2(MAP_SIZE)-1:0]    cell_x,
   output logic [$clog2(MAP_SIZE)-1:0]    cell_y
);

   localparam int D_W    = $clog2(MAX_RANGE);
   localparam int RW     = $clog2(MAP_SIZE);
   localparam int PW     = D_W + pp2og_pkg::TRIG_W;
   localparam int CM_L   = $clog2(CM_PER_CELL);
   localparam int DIV_SH = D_W + CM_L;
   localparam int M_W    = D_W + 1;
   localparam int QW     = D_W + M_W;
   localparam int KW     = QW - DIV_SH;
   localparam int EW     = ((D_W > RW) ? D_W : RW) + 2;
   // ceil(2^DIV_SH / CM_PER_CELL): exact quotient for any D_W-bit dividend
   localparam logic [M_W-1:0] DIV_M = M_W'(((2 ** DIV_SH) + CM_PER_CELL - 1) / CM_PER_CELL);
   localparam logic signed [EW-1:0] CELL_MAX = EW'(MAP_SIZE - 1);

   logic          v1_ff, v2_ff, v3_ff;
   logic [PW-1:0] s_prod_ff, c_prod_ff;
   logic          left1_ff, cneg1_ff, left2_ff, cneg2_ff;
   logic [QW-1:0] s_quo_ff, c_quo_ff;
   logic [QW-1:0] s_quo_in, c_quo_in;
   logic [RW-1:0] x_ff, y_ff, x_in, y_in;

   logic [KW-1:0]         kc, ks;
   logic signed [EW-1:0]  kc_s, ks_s, x_raw, y_raw;

   // product >> 16 stays below 2^D_W since the trig value is at most 1.0
   assign s_quo_in = QW'(s_prod_ff[16 +: D_W]) * QW'(DIV_M);
   assign c_quo_in = QW'(c_prod_ff[16 +: D_W]) * QW'(DIV_M);

   assign kc   = c_quo_ff[DIV_SH +: KW];
   assign ks   = s_quo_ff[DIV_SH +: KW];
   assign kc_s = $signed(EW'(kc));
   assign ks_s = $signed(EW'(ks));

   always_comb begin
      x_raw = (left2_ff ? CELL_MAX : EW'(0)) + (cneg2_ff ? -kc_s : kc_s);
      y_raw = CELL_MAX - ks_s;
      if (x_raw < 0) begin
         x_in = '0;
      end else if (x_raw > CELL_MAX) begin
         x_in = RW'(MAP_SIZE - 1);
      end else begin
         x_in = RW'(x_raw);
      end
      if (y_raw < 0) begin
         y_in = '0;
      end else if (y_raw > CELL_MAX) begin
         y_in = RW'(MAP_SIZE - 1);
      end else begin
         y_in = RW'(y_raw);
      end
   end

   always_ff @(posedge clock) begin
      s_prod_ff <= PW'(range_cm) * PW'(sin_val);
      c_prod_ff <= PW'(range_cm) * PW'(cos_val);
      left1_ff  <= ctl.left;
      cneg1_ff  <= ctl.cneg;
      s_quo_ff  <= s_quo_in;
      c_quo_ff  <= c_quo_in;
      left2_ff  <= left1_ff;
      cneg2_ff  <= cneg1_ff;
      x_ff      <= x_in;
      y_ff      <= y_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= ctl.start;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign cell_x    = x_ff;
   assign cell_y    = y_ff;

endmodule

[sv/polar_point_to_occupancy_grid_core.sv]
// Channel   Dir  Handshake      Carries
// req_chan  in   valid/ready    command, distance_cm, angle_tenths, read_x, read_y
// rsp_chan  out  valid/ready    cell_x, cell_y, cell_value, done_res
//
// One request at a time. Between accept and the next ready, a plot runs a ROM
// read, two multiply stages, a layout stage, then a read-modify-write of one
// map row; a read runs a row read; clear and unused command only respond.
// Reset and clear drop per-row valid flops at once; no sweep of the map.
// A finished response waits in the output register; the next request is
// taken meanwhile and holds in its last state until that register frees.
// Depends on pp2og_pkg, pp2og_if, pp2og_trig_rom, pp2og_cell_calc, pp2og_map_ram.
`include "polar_point_to_occupancy_grid_core_assert.svh"

module polar_point_to_occupancy_grid_core #(
   parameter int MAP_SIZE    = 120,
   parameter int CM_PER_CELL = 20,
   parameter int MAX_RANGE   = 1200
) (
   input logic          clock,
   input logic          reset,
   pp2og_req_if.sink    req_chan,
   pp2og_rsp_if.source  rsp_chan
);

   localparam int D_W    = $clog2(MAX_RANGE);
   localparam int RW     = $clog2(MAP_SIZE);
   localparam int CW     = pp2og_pkg::COORD_W;
   localparam int AW     = pp2og_pkg::ROM_AW;
   localparam int ANG_W  = pp2og_pkg::ANGLE_W;
   localparam int DIST_W = pp2og_pkg::DIST_W;

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_ROM       = 3'd1;
   localparam logic [2:0] ST_CALC_GO   = 3'd2;
   localparam logic [2:0] ST_CALC_WAIT = 3'd3;
   localparam logic [2:0] ST_MEMRD     = 3'd4;
   localparam logic [2:0] ST_MEMWR     = 3'd5;
   localparam logic [2:0] ST_RESP      = 3'd6;

   logic [2:0]                   state_ff, state_in;
   logic [pp2og_pkg::CMD_W-1:0]  cmd_ff, cmd_in;
   logic [D_W-1:0]               dist_ff, dist_in;
   logic [ANG_W-1:0]             angle_ff, angle_in;
   logic [RW-1:0]                x_ff, x_in, y_ff, y_in;
   logic                         in_map_ff, in_map_in;
   logic [CW-1:0]                res_x_ff, res_x_in, res_y_ff, res_y_in;
   logic                         res_val_ff, res_val_in, res_done_ff, res_done_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]                rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic                         rsp_val_ff, rsp_val_in, rsp_done_ff, rsp_done_in;

   logic                         req_accept;
   logic                         read_in_map;
   logic [D_W-1:0]               dist_clamp;
   logic [ANG_W-1:0]             angle_clamp;
   logic                         ang_left, ang_cneg;
   logic [AW-1:0]                sin_addr, cos_addr;
   logic [pp2og_pkg::TRIG_W-1:0] sin_q, cos_q;
   pp2og_pkg::calc_ctl_type      calc_ctl;
   logic                         calc_valid;
   logic [RW-1:0]                calc_x, calc_y;
   pp2og_pkg::ram_ctl_type       ram_ctl;
   logic [MAP_SIZE-1:0]          rd_row, wr_row;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;

   assign dist_clamp = (req_chan.distance_cm > DIST_W'(MAX_RANGE - 1)) ?
                       D_W'(MAX_RANGE - 1) : D_W'(req_chan.distance_cm);
   assign angle_clamp = (req_chan.angle_tenths > pp2og_pkg::ANGLE_LAST) ?
                        pp2og_pkg::ANGLE_LAST : req_chan.angle_tenths;
   assign read_in_map = (32'(req_chan.read_x) < MAP_SIZE) && (32'(req_chan.read_y) < MAP_SIZE);

   // second quadrant folds onto the table with a negative cosine
   assign ang_left = (angle_ff >= pp2og_pkg::ANGLE_QUARTER);
   assign ang_cneg = (angle_ff > pp2og_pkg::ANGLE_QUARTER);
   assign sin_addr = AW'(ang_cneg ? (pp2og_pkg::ANGLE_HALF - angle_ff) : angle_ff);
   assign cos_addr = AW'(ang_cneg ? (angle_ff - pp2og_pkg::ANGLE_QUARTER)
                                  : (pp2og_pkg::ANGLE_QUARTER - angle_ff));

   assign wr_row = rd_row | (MAP_SIZE'(1) << x_ff);

   pp2og_trig_rom u_trig_rom (
      .clock    (clock),
      .sin_addr (sin_addr),
      .cos_addr (cos_addr),
      .sin_q    (sin_q),
      .cos_q    (cos_q)
   );

   pp2og_cell_calc #(
      .MAP_SIZE    (MAP_SIZE),
      .CM_PER_CELL (CM_PER_CELL),
      .MAX_RANGE   (MAX_RANGE)
   ) u_cell_calc (
      .clock     (clock),
      .reset     (reset),
      .ctl       (calc_ctl),
      .range_cm  (dist_ff),
      .sin_val   (sin_q),
      .cos_val   (cos_q),
      .out_valid (calc_valid),
      .cell_x    (calc_x),
      .cell_y    (calc_y)
   );

   pp2og_map_ram #(
      .MAP_SIZE (MAP_SIZE)
   ) u_map_ram (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ram_ctl),
      .rd_addr (y_ff),
      .wr_addr (y_ff),
      .wr_row  (wr_row),
      .rd_row  (rd_row)
   );

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      dist_in      = dist_ff;
      angle_in     = angle_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      in_map_in    = in_map_ff;
      res_x_in     = res_x_ff;
      res_y_in     = res_y_ff;
      res_val_in   = res_val_ff;
      res_done_in  = res_done_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_done_in  = rsp_done_ff;
      calc_ctl       = '0;
      calc_ctl.left  = ang_left;
      calc_ctl.cneg  = ang_cneg;
      ram_ctl        = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cmd_in      = req_chan.command;
               dist_in     = dist_clamp;
               angle_in    = angle_clamp;
               res_x_in    = '0;
               res_y_in    = '0;
               res_val_in  = 1'b0;
               res_done_in = 1'b1;
               case (req_chan.command)
                  pp2og_pkg::CMD_PLOT: begin
                     state_in = ST_ROM;
                  end
                  pp2og_pkg::CMD_READ: begin
                     res_x_in  = req_chan.read_x;
                     res_y_in  = req_chan.read_y;
                     in_map_in = read_in_map;
                     x_in      = read_in_map ? RW'(req_chan.read_x) : '0;
                     y_in      = read_in_map ? RW'(req_chan.read_y) : '0;
                     state_in  = ST_MEMRD;
                  end
                  pp2og_pkg::CMD_CLEAR: begin
                     ram_ctl.clear = 1'b1;
                     state_in      = ST_RESP;
                  end
                  default: begin
                     res_done_in = 1'b0;
                     state_in    = ST_RESP;
                  end
               endcase
            end
         end
         ST_ROM: begin
            state_in = ST_CALC_GO;
         end
         ST_CALC_GO: begin
            calc_ctl.start = 1'b1;
            state_in       = ST_CALC_WAIT;
         end
         ST_CALC_WAIT: begin
            if (calc_valid) begin
               x_in      = calc_x;
               y_in      = calc_y;
               in_map_in = 1'b1;
               res_x_in  = CW'(calc_x);
               res_y_in  = CW'(calc_y);
               state_in  = ST_MEMRD;
            end
         end
         ST_MEMRD: begin
            state_in = ST_MEMWR;
         end
         ST_MEMWR: begin
            if (cmd_ff == pp2og_pkg::CMD_PLOT) begin
               ram_ctl.wr_en = 1'b1;
            end else begin
               res_val_in = in_map_ff && rd_row[x_ff];
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = res_x_ff;
               rsp_y_in     = res_y_ff;
               rsp_val_in   = res_val_ff;
               rsp_done_in  = res_done_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      dist_ff     <= dist_in;
      angle_ff    <= angle_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      in_map_ff   <= in_map_in;
      res_x_ff    <= res_x_in;
      res_y_ff    <= res_y_in;
      res_val_ff  <= res_val_in;
      res_done_ff <= res_done_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_val_ff  <= rsp_val_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.cell_x     = rsp_x_ff;
   assign rsp_chan.cell_y     = rsp_y_ff;
   assign rsp_chan.cell_value = rsp_val_ff;
   assign rsp_chan.done_res   = rsp_done_ff;

   `PP2OG_ASSERT_NXT(a_write_then_resp, clock, reset, ram_ctl.wr_en, state_ff == ST_RESP)
   `PP2OG_ASSERT_IMP(a_calc_when_waiting, clock, reset, calc_valid, state_ff == ST_CALC_WAIT)
   `PP2OG_ASSERT_IMP(a_row_in_map, clock, reset, state_ff == ST_MEMRD, (32'(x_ff) < MAP_SIZE) && (32'(y_ff) < MAP_SIZE))
   `PP2OG_ASSERT_NXT(a_resp_holds, clock, reset, (state_ff == ST_RESP) && rsp_valid_ff && !rsp_chan.ready, state_ff == ST_RESP)

endmodule
